// File: rtl/cbim_pkg.sv
// ----------------------------------------------------------------------------
// cbim_pkg: cartridge bank and IRQ mapper definitions
// Address decode codes, prescaler period and the result word layout.
// ----------------------------------------------------------------------------
package cbim_pkg;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned CHR_NUM    = 8;

    localparam logic [7:0] PRESCALE_PERIOD = 8'h72;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;

    localparam logic [3:0] TOP_PRG0 = 4'h8;
    localparam logic [3:0] TOP_PRG1 = 4'hA;
    localparam logic [3:0] TOP_CHR0 = 4'hB;
    localparam logic [3:0] TOP_CHR1 = 4'hC;
    localparam logic [3:0] TOP_CHR2 = 4'hD;
    localparam logic [3:0] TOP_CHR3 = 4'hE;
    localparam logic [3:0] TOP_IRQ  = 4'hF;

    localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL  = 2'd2;
    localparam logic [1:0] IRQ_ACK      = 2'd3;

    localparam logic [2:0] SLOT_PRG0 = 3'd4;
    localparam logic [2:0] SLOT_PRG1 = 3'd5;

    localparam logic REQ_WRITE = 1'b0;

    typedef struct packed {
        logic       irq_pending;
        logic       irq_line;
        logic [7:0] bank_number;
        logic [2:0] bank_slot;
        logic       bank_is_program;
        logic       bank_valid;
    } result_t;

endpackage

// File: rtl/cartridge_bank_and_irq_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_and_irq_mapper: program/character bank select and IRQ counter
// An accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle while the output is not stalled; the two registers
// part the two sides, so a new word can be taken while a result waits.
// Reset (rst_n low, async): char banks hold their index, IRQ state cleared,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
module cartridge_bank_and_irq_mapper
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] address, [23:16] write_data, [30:24] tick_cycles, [31] zero
    input  logic [cbim_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] bank_slot, [10:3] bank_number, [11] irq_line, [12] irq_pending
    output logic [cbim_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] bank_valid, [1] bank_is_program
    output logic [1:0]                       m_axis_tuser
);
    import cbim_pkg::*;

    logic                  in_valid_reg;
    logic                  in_req_reg;
    logic [15:0]           in_addr_reg;
    logic [7:0]            in_wdata_reg;
    logic [6:0]            in_cyc_reg;

    logic                  out_valid_reg;
    result_t               out_reg;

    logic [7:0]            chr_reg [CHR_NUM];
    logic [1:0]            en_reg;
    logic [7:0]            count_reg;
    logic [7:0]            reload_reg;
    logic                  occurred_reg;
    logic [6:0]            prescale_reg;
    logic                  level_reg;

    logic [7:0]            chr_next [CHR_NUM];
    logic [1:0]            en_next;
    logic [7:0]            count_next;
    logic [7:0]            reload_next;
    logic                  occurred_next;
    logic [6:0]            prescale_next;
    logic                  level_next;
    result_t               out_next;

    logic                  advance;
    logic [3:0]            top;
    logic [3:0]            nib;
    logic [2:0]            chr_idx;
    logic [3:0]            chr_off;
    logic [7:0]            chr_val;
    logic [7:0]            cyc_sat;
    logic [7:0]            acc;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign top     = in_addr_reg[15:12];
    assign nib     = in_wdata_reg[3:0];
    assign chr_off = top - TOP_CHR0;
    assign chr_idx = {chr_off[1:0], in_addr_reg[3]};
    assign cyc_sat = ({1'b0, in_cyc_reg} > PRESCALE_PERIOD) ? PRESCALE_PERIOD
                                                             : {1'b0, in_cyc_reg};
    assign acc     = {1'b0, prescale_reg} + cyc_sat;

    always_comb
    begin
        chr_val       = chr_reg[chr_idx];
        chr_next      = chr_reg;
        en_next       = en_reg;
        count_next    = count_reg;
        reload_next   = reload_reg;
        occurred_next = occurred_reg;
        prescale_next = prescale_reg;
        level_next    = level_reg;
        out_next      = '0;

        if (in_req_reg != REQ_WRITE)
        begin
            if (en_reg[1])
            begin
                if (acc >= PRESCALE_PERIOD)
                begin
                    prescale_next = 7'(acc - PRESCALE_PERIOD);
                    if (count_reg == COUNT_MAX)
                    begin
                        occurred_next = 1'b1;
                        count_next    = reload_reg;
                        en_next       = {en_reg[0], en_reg[0]};
                        level_next    = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                else
                begin
                    prescale_next = acc[6:0];
                end
            end
        end
        else
        begin
            unique case (top)
                TOP_PRG0, TOP_PRG1:
                begin
                    out_next.bank_valid      = 1'b1;
                    out_next.bank_is_program = 1'b1;
                    out_next.bank_slot       = (top == TOP_PRG0) ? SLOT_PRG0 : SLOT_PRG1;
                    out_next.bank_number     = in_wdata_reg;
                end
                TOP_CHR0, TOP_CHR1, TOP_CHR2, TOP_CHR3:
                begin
                    if (!in_addr_reg[2])
                        chr_val = {chr_reg[chr_idx][7:4], nib};
                    else
                        chr_val = {nib, chr_reg[chr_idx][3:0]};
                    chr_next[chr_idx]    = chr_val;
                    out_next.bank_valid  = 1'b1;
                    out_next.bank_slot   = chr_idx;
                    out_next.bank_number = chr_val;
                end
                TOP_IRQ:
                begin
                    occurred_next = 1'b0;
                    unique case (in_addr_reg[3:2])
                        IRQ_LATCH_LO: reload_next = {reload_reg[7:4], nib};
                        IRQ_LATCH_HI: reload_next = {nib, reload_reg[3:0]};
                        IRQ_CONTROL:
                        begin
                            en_next    = in_wdata_reg[1:0];
                            level_next = 1'b0;
                            if (in_wdata_reg[1])
                            begin
                                count_next    = reload_reg;
                                prescale_next = '0;
                            end
                        end
                        IRQ_ACK:
                        begin
                            en_next    = {en_reg[0], en_reg[0]};
                            level_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        out_next.irq_line    = level_next;
        out_next.irq_pending = occurred_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHR_NUM; i++)
                chr_reg[i] <= 8'(i);
            en_reg        <= '0;
            count_reg     <= '0;
            reload_reg    <= '0;
            occurred_reg  <= 1'b0;
            prescale_reg  <= '0;
            level_reg     <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                chr_reg      <= chr_next;
                en_reg       <= en_next;
                count_reg    <= count_next;
                reload_reg   <= reload_next;
                occurred_reg <= occurred_next;
                prescale_reg <= prescale_next;
                level_reg    <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg   <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[15:0];
            in_wdata_reg <= s_axis_tdata[23:16];
            in_cyc_reg   <= s_axis_tdata[30:24];
        end
        if (advance)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.irq_pending, out_reg.irq_line,
                            out_reg.bank_number, out_reg.bank_slot};
    assign m_axis_tuser  = {out_reg.bank_is_program, out_reg.bank_valid};

    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, prescale_reg} < PRESCALE_PERIOD)
        else $error("prescaler out of range");

    a_occurred_level: assert property (@(posedge clk) disable iff (!rst_n)
        occurred_reg |-> level_reg)
        else $error("occurred flag set with IRQ line low");

    a_no_bank_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.bank_valid) |->
        (!out_reg.bank_is_program && out_reg.bank_slot == '0 && out_reg.bank_number == '0))
        else $error("bank fields set without bank change");

    a_prg_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.bank_is_program) |->
        (out_reg.bank_slot == SLOT_PRG0 || out_reg.bank_slot == SLOT_PRG1))
        else $error("program bank with bad slot");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |=> in_valid_reg)
        else $error("input word dropped while output stalled");

endmodule
